>>> rtl/core/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
// Holds the order slot record, status codes and order type codes.
// No dependencies.
`default_nettype none

package lobm_pkg;

    localparam int DefOrderSlots  = 64;
    localparam int DefPriceLevels = 256;
    localparam int IdW            = 32;
    localparam int PriceW         = 8;
    localparam int QtyW           = 24;
    localparam int TotW           = 30;
    localparam int StampW         = 48;
    localparam int TrW            = 6;
    localparam int MaxTrades      = 63;

    typedef enum logic [2:0] {
        ST_RESTED     = 3'd0,
        ST_FILLED     = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_DUPLICATE  = 3'd3,
        ST_FOK_REJECT = 3'd4,
        ST_CANCELLED  = 3'd5,
        ST_NOT_FOUND  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        OT_GTC    = 2'd0,
        OT_IOC    = 2'd1,
        OT_FOK    = 2'd2,
        OT_MARKET = 2'd3
    } t_otype;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;
    localparam logic SIDE_BUY   = 1'b0;

    // One resting order. The stamp orders arrivals for time priority.
    typedef struct packed {
        logic [IdW-1:0]    id;
        logic              side;
        logic [PriceW-1:0] price;
        logic [QtyW-1:0]   rem;
        logic [StampW-1:0] stamp;
    } t_slot;

endpackage

`default_nettype wire

>>> rtl/core/limit_order_book_matcher_unit.sv
// Price-time priority limit order book with matching, top level.
// Depends on lobm_pkg for the slot record, status and order type codes.
//
//   channel  handshake                  payload
//   input    i_in_valid / o_in_ready    i_command .. i_quantity
//   output   o_out_valid / i_out_ready  o_is_trade .. o_last
//
// Every pass over the order slots reads the slot memory one entry a cycle. An
// item takes one pass and a decision, then one more pass and decision per
// trade; resting a remainder adds a free-slot search over the valid bits.
// Reset clears the valid bits, the trade number and the arrival stamp; the
// block is ready the cycle after reset. A stalled output holds the sequencer
// whenever it has a result to load.
`default_nettype none

module limit_order_book_matcher_unit
    import lobm_pkg::*;
#(
    parameter int ORDER_SLOTS  = DefOrderSlots,
    parameter int PRICE_LEVELS = DefPriceLevels
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_command,
    input  wire logic [IdW-1:0]    i_order_id,
    input  wire logic              i_side,
    input  wire logic [1:0]        i_order_type,
    input  wire logic [PriceW-1:0] i_limit_price,
    input  wire logic [QtyW-1:0]   i_quantity,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_is_trade,
    output logic [IdW-1:0]         o_trade_id,
    output logic [IdW-1:0]         o_buy_order_id,
    output logic [IdW-1:0]         o_sell_order_id,
    output logic [PriceW-1:0]      o_trade_price,
    output logic [QtyW-1:0]        o_trade_quantity,
    output logic [2:0]             o_status,
    output logic                   o_last
);

    localparam int SW = $clog2(ORDER_SLOTS);
    localparam logic [SW:0] SlotEnd = (SW+1)'(ORDER_SLOTS);
    localparam bit Clamp = PRICE_LEVELS < 256;
    localparam logic [PriceW-1:0] PriceMax = PriceW'(PRICE_LEVELS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_FREE} t_state;

    t_state               r_state;
    logic                 r_cmd;
    logic [IdW-1:0]       r_id;
    logic                 r_side;
    t_otype               r_type;
    logic [PriceW-1:0]    r_price;
    logic [QtyW-1:0]      r_qty;
    logic [QtyW-1:0]      r_rem;
    logic [TrW-1:0]       r_ntr;
    logic                 r_first;
    logic [IdW-1:0]       r_tnum;
    logic [StampW-1:0]    r_stamp;
    logic [ORDER_SLOTS-1:0] r_valid;

    logic [SW:0]          r_idx;
    logic                 r_rd_vld;
    logic [SW-1:0]        r_rd_idx;
    t_slot                r_rd;

    logic                 r_found;
    logic [SW-1:0]        r_fnd_idx;
    logic [TotW-1:0]      r_avail;
    logic                 r_bfound;
    logic [SW-1:0]        r_bidx;
    t_slot                r_bent;

    logic                 r_ovld;
    logic                 r_otr;
    logic [IdW-1:0]       r_otid;
    logic [IdW-1:0]       r_obuy;
    logic [IdW-1:0]       r_osell;
    logic [PriceW-1:0]    r_oprice;
    logic [QtyW-1:0]      r_oqty;
    t_status              r_ostat;
    logic                 r_olast;

    t_slot                mem [ORDER_SLOTS];

    logic                 w_opp;
    logic                 w_v;
    logic                 w_hit;
    logic                 w_is_opp;
    logic                 w_fok_ok;
    logic                 w_better;
    logic                 w_early;
    t_status              w_early_st;
    logic                 w_fill_ok;
    logic [QtyW-1:0]      w_tq;
    logic [QtyW-1:0]      w_new_rem;
    logic                 w_out_free;
    logic                 w_oload;
    logic                 w_do_fill;
    logic                 w_do_rest;
    logic                 w_we;
    logic [SW-1:0]        w_waddr;
    t_slot                w_wdata;
    logic [PriceW-1:0]    w_price;

    always_comb begin
        w_price = (Clamp && i_limit_price > PriceMax) ? PriceMax : i_limit_price;
        w_opp = ~r_side;
        w_v = r_valid[r_rd_idx];
        w_hit = w_v && (r_rd.id == r_id);
        w_is_opp = w_v && (r_rd.side == w_opp);
        w_fok_ok = (r_side == SIDE_BUY) ? (r_rd.price <= r_price) : (r_rd.price >= r_price);
        // Best opposite level first, then the oldest arrival at that level.
        w_better = !r_bfound
            || (w_opp ? (r_rd.price < r_bent.price) : (r_rd.price > r_bent.price))
            || ((r_rd.price == r_bent.price) && (r_rd.stamp < r_bent.stamp));

        w_early = 1'b1;
        w_early_st = ST_FILLED;
        if (r_cmd == CMD_CANCEL) begin
            w_early_st = r_found ? ST_CANCELLED : ST_NOT_FOUND;
        end else if (r_found) begin
            w_early_st = ST_DUPLICATE;
        end else if (r_qty == '0) begin
            w_early_st = ST_FILLED;
        end else if (r_type == OT_FOK && r_avail < TotW'(r_qty)) begin
            w_early_st = ST_FOK_REJECT;
        end else begin
            w_early = 1'b0;
        end

        w_fill_ok = (r_rem != '0) && (r_ntr != TrW'(MaxTrades)) && r_bfound
            && ((r_type == OT_MARKET)
                || ((r_side == SIDE_BUY) ? (r_bent.price <= r_price)
                                         : (r_bent.price >= r_price)));
        w_tq = (r_rem < r_bent.rem) ? r_rem : r_bent.rem;
        w_new_rem = r_bent.rem - w_tq;
        w_out_free = !r_ovld || i_out_ready;

        // A new result enters the output register this cycle.
        w_oload = w_out_free && (
            ((r_state == S_DECIDE) && ((r_first && w_early) || w_fill_ok
                || !(r_rem != '0 && (r_type == OT_GTC || r_type == OT_FOK))))
            || ((r_state == S_FREE)
                && ((r_idx == SlotEnd) || !r_valid[r_idx[SW-1:0]])));

        w_do_fill = (r_state == S_DECIDE) && !(r_first && w_early) && w_fill_ok && w_out_free;
        w_do_rest = (r_state == S_FREE) && (r_idx != SlotEnd)
            && !r_valid[r_idx[SW-1:0]] && w_out_free;

        w_we = w_do_fill || w_do_rest;
        w_waddr = w_do_fill ? r_bidx : r_idx[SW-1:0];
        w_wdata = r_bent;
        w_wdata.rem = w_new_rem;
        if (w_do_rest) begin
            w_wdata.id = r_id;
            w_wdata.side = r_side;
            w_wdata.price = r_price;
            w_wdata.rem = r_rem;
            w_wdata.stamp = r_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[r_idx[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_tnum <= '0;
            r_stamp <= '0;
            r_ovld <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_ovld && i_out_ready && !w_oload) begin
                r_ovld <= 1'b0;
            end

            // Slot pass: one read issued a cycle, evaluated in the next cycle.
            if (r_rd_vld) begin
                if (w_hit) begin
                    r_found <= 1'b1;
                    r_fnd_idx <= r_rd_idx;
                end
                if (w_is_opp && w_fok_ok) begin
                    r_avail <= r_avail + TotW'(r_rd.rem);
                end
                if (w_is_opp && w_better) begin
                    r_bfound <= 1'b1;
                    r_bidx <= r_rd_idx;
                    r_bent <= r_rd;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd <= i_command;
                        r_id <= i_order_id;
                        r_side <= i_side;
                        r_type <= t_otype'(i_order_type);
                        r_price <= w_price;
                        r_qty <= i_quantity;
                        r_rem <= i_quantity;
                        r_ntr <= '0;
                        r_first <= 1'b1;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_avail <= '0;
                        r_bfound <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx != SlotEnd) begin
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_idx[SW-1:0];
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_first && w_early) begin
                        if (w_out_free) begin
                            r_ovld <= 1'b1;
                            r_otr <= 1'b0;
                            r_otid <= '0;
                            r_obuy <= '0;
                            r_osell <= '0;
                            r_oprice <= '0;
                            r_oqty <= '0;
                            r_ostat <= w_early_st;
                            r_olast <= 1'b1;
                            if (r_cmd == CMD_CANCEL && r_found) begin
                                r_valid[r_fnd_idx] <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end
                    end else if (w_fill_ok) begin
                        if (w_out_free) begin
                            r_ovld <= 1'b1;
                            r_otr <= 1'b1;
                            r_otid <= r_tnum;
                            r_obuy <= (r_side == SIDE_BUY) ? r_id : r_bent.id;
                            r_osell <= (r_side == SIDE_BUY) ? r_bent.id : r_id;
                            r_oprice <= r_bent.price;
                            r_oqty <= w_tq;
                            r_ostat <= ST_RESTED;
                            r_olast <= 1'b0;
                            if (w_new_rem == '0) begin
                                r_valid[r_bidx] <= 1'b0;
                            end
                            r_tnum <= r_tnum + 1'b1;
                            r_ntr <= r_ntr + 1'b1;
                            r_rem <= r_rem - w_tq;
                            r_first <= 1'b0;
                            r_idx <= '0;
                            r_found <= 1'b0;
                            r_avail <= '0;
                            r_bfound <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_first <= 1'b0;
                        if (r_rem != '0 && (r_type == OT_GTC || r_type == OT_FOK)) begin
                            r_idx <= '0;
                            r_state <= S_FREE;
                        end else if (w_out_free) begin
                            r_ovld <= 1'b1;
                            r_otr <= 1'b0;
                            r_otid <= '0;
                            r_obuy <= '0;
                            r_osell <= '0;
                            r_oprice <= '0;
                            r_oqty <= '0;
                            r_ostat <= (r_rem == '0) ? ST_FILLED : ST_DROPPED;
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FREE: begin
                    // Lowest free slot takes the remainder; a full book drops it.
                    if (r_idx == SlotEnd || !r_valid[r_idx[SW-1:0]]) begin
                        if (w_out_free) begin
                            r_ovld <= 1'b1;
                            r_otr <= 1'b0;
                            r_otid <= '0;
                            r_obuy <= '0;
                            r_osell <= '0;
                            r_oprice <= '0;
                            r_oqty <= '0;
                            r_olast <= 1'b1;
                            if (r_idx == SlotEnd) begin
                                r_ostat <= ST_DROPPED;
                            end else begin
                                r_ostat <= ST_RESTED;
                                r_valid[r_idx[SW-1:0]] <= 1'b1;
                                r_stamp <= r_stamp + 1'b1;
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_ovld;
    assign o_is_trade       = r_otr;
    assign o_trade_id       = r_otid;
    assign o_buy_order_id   = r_obuy;
    assign o_sell_order_id  = r_osell;
    assign o_trade_price    = r_oprice;
    assign o_trade_quantity = r_oqty;
    assign o_status         = r_ostat;
    assign o_last           = r_olast;

endmodule

`default_nettype wire

>>> bench/limit_order_book_matcher_unit_tb.sv
// Self-checking testbench for limit_order_book_matcher_unit: a price-time order book model
// predicts trades and status results, and random handshake gaps exercise both channels.
// Depends on lobm_pkg and the matcher RTL only.
`default_nettype none

module limit_order_book_matcher_unit_tb;
    import lobm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  BookSlots  = 64;
    localparam int  CycleLimit = 8000000;

    typedef struct {
        logic              is_trade;
        logic [IdW-1:0]    trade_id;
        logic [IdW-1:0]    buy_id;
        logic [IdW-1:0]    sell_id;
        logic [PriceW-1:0] price;
        logic [QtyW-1:0]   qty;
        t_status           status;
        logic              last;
    } t_fill_report;

    // Book model plus the queue of reports it predicts.
    class t_book_scoreboard;
        bit              live   [BookSlots];
        bit [IdW-1:0]    id     [BookSlots];
        bit              sd     [BookSlots];
        bit [PriceW-1:0] px     [BookSlots];
        bit [QtyW-1:0]   left   [BookSlots];
        longint          arrival[BookSlots];
        longint          arrivals;
        bit [31:0]       trade_no;
        t_fill_report    pending[$];
        int              mismatches;

        function int find_order(bit [IdW-1:0] oid);
            for (int s = 0; s < BookSlots; s++)
                if (live[s] && id[s] == oid) return s;
            return -1;
        endfunction

        function void push_status(t_status st);
            t_fill_report r;
            r = '{1'b0, '0, '0, '0, '0, '0, st, 1'b1};
            pending = {pending, r};
        endfunction

        // Oldest order at the best price on book side bs, or -1 if that side is empty.
        function int best_resting(bit bs);
            int b;
            b = -1;
            for (int s = 0; s < BookSlots; s++) begin
                if (!live[s] || sd[s] != bs) continue;
                if (b < 0) b = s;
                else if (px[s] == px[b] ? arrival[s] < arrival[b]
                         : (bs ? px[s] < px[b] : px[s] > px[b])) b = s;
            end
            return b;
        endfunction

        function void note_input(logic cmd, logic [IdW-1:0] oid, logic side, t_otype ot,
                                 logic [PriceW-1:0] lim, logic [QtyW-1:0] qty);
            int s, b, trades, free;
            longint avail;
            bit [QtyW-1:0] rem, tq;
            t_fill_report r;
            s = find_order(oid);
            if (cmd == CMD_CANCEL) begin
                if (s < 0) push_status(ST_NOT_FOUND);
                else begin
                    live[s] = 0;
                    push_status(ST_CANCELLED);
                end
                return;
            end
            if (s >= 0) begin
                push_status(ST_DUPLICATE);
                return;
            end
            if (qty == 0) begin
                push_status(ST_FILLED);
                return;
            end
            if (ot == OT_FOK) begin
                avail = 0;
                for (int k = 0; k < BookSlots; k++)
                    if (live[k] && sd[k] != side &&
                        (side == SIDE_BUY ? px[k] <= lim : px[k] >= lim))
                        avail += left[k];
                if (avail < qty) begin
                    push_status(ST_FOK_REJECT);
                    return;
                end
            end
            rem = qty;
            trades = 0;
            while (rem > 0 && trades < MaxTrades) begin
                b = best_resting(!side);
                if (b < 0) break;
                if (ot != OT_MARKET && (side == SIDE_BUY ? px[b] > lim : px[b] < lim)) break;
                tq = rem < left[b] ? rem : left[b];
                r.is_trade = 1'b1;
                r.trade_id = trade_no;
                r.buy_id   = side == SIDE_BUY ? oid : id[b];
                r.sell_id  = side == SIDE_BUY ? id[b] : oid;
                r.price    = px[b];
                r.qty      = tq;
                r.status   = ST_RESTED;
                r.last     = 1'b0;
                pending = {pending, r};
                trade_no++;
                trades++;
                rem -= tq;
                left[b] -= tq;
                if (left[b] == 0) live[b] = 0;
            end
            if (rem == 0) push_status(ST_FILLED);
            else if (ot == OT_GTC || ot == OT_FOK) begin
                free = -1;
                for (int k = BookSlots - 1; k >= 0; k--)
                    if (!live[k]) free = k;
                if (free < 0) push_status(ST_DROPPED);
                else begin
                    live[free]    = 1;
                    id[free]      = oid;
                    sd[free]      = side;
                    px[free]      = lim;
                    left[free]    = rem;
                    arrival[free] = arrivals++;
                    push_status(ST_RESTED);
                end
            end else push_status(ST_DROPPED);
        endfunction

        function void check_result(t_fill_report got);
            t_fill_report exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result trade=%0b status=%0d",
                             got.is_trade, got.status);
                return;
            end
            exp = pending.pop_front();
            if (got.is_trade !== exp.is_trade || got.trade_id !== exp.trade_id ||
                got.buy_id !== exp.buy_id || got.sell_id !== exp.sell_id ||
                got.price !== exp.price || got.qty !== exp.qty ||
                got.status !== exp.status || got.last !== exp.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected tr=%0b tid=%0d b=%h s=%h p=%0d q=%0d st=%0d l=%0b",
                              " got tr=%0b tid=%0d b=%h s=%h p=%0d q=%0d st=%0d l=%0b"},
                             exp.is_trade, exp.trade_id, exp.buy_id, exp.sell_id, exp.price,
                             exp.qty, exp.status, exp.last, got.is_trade, got.trade_id,
                             got.buy_id, got.sell_id, got.price, got.qty, got.status,
                             got.last);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              command = CMD_ADD;
    logic [IdW-1:0]    order_id = '0;
    logic              side = 1'b0;
    logic [1:0]        order_type = OT_GTC;
    logic [PriceW-1:0] limit_price = '0;
    logic [QtyW-1:0]   quantity = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              is_trade, last;
    logic [IdW-1:0]    trade_id, buy_id, sell_id;
    logic [PriceW-1:0] trade_price;
    logic [QtyW-1:0]   trade_qty;
    logic [2:0]        status;
    bit                calm;
    int                stall_left;
    int                cycles;
    t_book_scoreboard  book = new();

    limit_order_book_matcher_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_command(command), .i_order_id(order_id), .i_side(side),
        .i_order_type(order_type), .i_limit_price(limit_price), .i_quantity(quantity),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_is_trade(is_trade), .o_trade_id(trade_id), .o_buy_order_id(buy_id),
        .o_sell_order_id(sell_id), .o_trade_price(trade_price),
        .o_trade_quantity(trade_qty), .o_status(status), .o_last(last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none during calm stretches.
    function int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            book.check_result('{is_trade, trade_id, buy_id, sell_id, trade_price,
                                trade_qty, t_status'(status), last});
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else begin
            stall_left <= idle_gap();
            out_ready  <= 1'b1;
        end
    end

    // Valid stays high between back-to-back items; it drops when a gap follows or the bench drains.
    task automatic send(logic cmd, logic [IdW-1:0] oid, logic sd, t_otype ot,
                        logic [PriceW-1:0] lim, logic [QtyW-1:0] qty);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        order_id    <= oid;
        side        <= sd;
        order_type  <= ot;
        limit_price <= lim;
        quantity    <= qty;
        do @(posedge i_clk); while (!in_ready);
        book.note_input(cmd, oid, sd, ot, lim, qty);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [IdW-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 40);
        if (r < 95) return $urandom;
        return r[0] ? '1 : '0;
    endfunction

    function automatic logic [QtyW-1:0] pick_qty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return QtyW'($urandom_range(1, 20));
        if (r < 88) return QtyW'($urandom_range(0, 200));
        return QtyW'($urandom);
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: boundary ids, prices and quantities, every type and every status except cancelled.
        send(CMD_CANCEL, 32'd5, 1'b1, OT_MARKET, 8'hFF, '1);
        send(CMD_ADD, '0, SIDE_BUY, OT_GTC, 8'd0, '1);
        send(CMD_ADD, '0, 1'b1, OT_GTC, 8'd0, 24'd3);
        send(CMD_ADD, '1, 1'b1, OT_GTC, 8'd255, 24'd10);
        send(CMD_ADD, 32'd7, SIDE_BUY, OT_GTC, 8'd50, 24'd0);
        send(CMD_ADD, 32'd8, SIDE_BUY, OT_FOK, 8'd255, 24'd11);
        send(CMD_ADD, 32'd9, SIDE_BUY, OT_FOK, 8'd255, 24'd4);
        send(CMD_ADD, 32'd10, SIDE_BUY, OT_IOC, 8'd200, 24'd20);
        send(CMD_ADD, 32'd11, SIDE_BUY, OT_MARKET, 8'd0, 24'd9);
        send(CMD_ADD, 32'd12, 1'b1, OT_MARKET, 8'd255, '1);
        send(CMD_ADD, 32'd13, 1'b1, OT_IOC, 8'd255, 24'd5);
        send(CMD_ADD, 32'd14, 1'b1, OT_FOK, 8'd0, 24'd2);
        send(CMD_CANCEL, 32'd14, SIDE_BUY, OT_GTC, 8'd0, '0);
        send(CMD_CANCEL, 32'd14, SIDE_BUY, OT_GTC, 8'd0, '0);
        drain();

        // Fill the book, overflow it, then sweep all but one order with one market order.
        for (int k = 0; k < BookSlots; k++)
            send(CMD_ADD, 32'd1000 + k, 1'b1, OT_GTC, PriceW'($urandom_range(100, 110)),
                 24'd1);
        send(CMD_ADD, 32'd2000, 1'b1, OT_GTC, 8'd90, 24'd1);
        send(CMD_ADD, 32'd2001, SIDE_BUY, OT_MARKET, 8'd0, 24'd500);
        send(CMD_ADD, 32'd2002, SIDE_BUY, OT_GTC, 8'd255, 24'd100);
        drain();
        repeat (300) @(posedge i_clk);
        // The last buy took the one sell left after the sweep, so it is all that rests.
        send(CMD_CANCEL, 32'd2002, 1'b0, OT_GTC, 8'd0, '0);

        // Random traffic around a narrow price band.
        for (int n = 0; n < 48; n++) begin
            if (n % 16 == 0) calm = !calm;
            if (n == 24) drain();
            if ($urandom_range(0, 99) < 25)
                send(CMD_CANCEL, pick_id(), 1'($urandom), t_otype'($urandom_range(0, 3)),
                     PriceW'($urandom), QtyW'($urandom));
            else
                send(CMD_ADD, pick_id(), 1'($urandom), t_otype'($urandom_range(0, 3)),
                     $urandom_range(0, 99) < 88 ? PriceW'($urandom_range(120, 130))
                                                : PriceW'($urandom),
                     pick_qty());
        end
        drain();
        repeat (300) @(posedge i_clk);
        if (book.mismatches == 0 && book.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire
